>>> rtl/atc_pkg.sv
// atc_pkg: shared types and constants for the trigram count table
// used by atc_ctrl, atc_dp and the top level; no dependencies
`default_nettype none

package atc_pkg;

	// table depth must be a power of two; probes wrap through the low index bits
	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int COUNT_BITS    = 32;
	localparam int KEY_W         = 24;
	localparam int SUM_W         = 32;
	localparam int ACC_W         = ((COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W) + 1;

	localparam logic [7:0]            SPACE_BYTE = 8'h20;
	localparam logic [31:0]           HASH_MULT  = 32'h9E3779B1;
	localparam logic [SUM_W-1:0]      SUM_MAX    = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_INDEX,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic [KEY_W-1:0]      key;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic hash;
		logic probe_init;
		logic rd;
		logic cmp;
		logic next_key;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need1;
		logic need2;
		logic last;
		logic phase;
		logic resolved;
		logic probe_last;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/atc_dp.sv
// atc_dp: datapath with byte history, hash, probe index and the entry memory
// depends on atc_pkg; driven by atc_ctrl commands
`default_nettype none

module atc_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire atc_pkg::cmd_t            cmd,
	output atc_pkg::sts_t                 sts,
	input  wire logic                     mode,
	input  wire logic [7:0]               char_byte,
	input  wire logic                     last_byte,
	output logic [atc_pkg::SUM_W-1:0]     weight_sum,
	output logic [atc_pkg::SUM_W-1:0]     total_trigrams,
	output logic                          table_full
);
	import atc_pkg::*;

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;
	entry_t mem_wd;
	logic   mem_we;

	logic             query_q, last_q, need1_q, need2_q, phase_q, full_q;
	logic [15:0]      prev_q;
	logic [1:0]       pos_q;
	logic [KEY_W-1:0] key1_q, key2_q, cur_key;
	logic [31:0]      prod_s1;
	logic [IDX_W-1:0] idx_q, probe_q;
	logic [SUM_W-1:0] run_q, total_q;

	logic             match, resolved, probe_last, apply;
	logic [ACC_W-1:0] acc;

	assign cur_key    = phase_q ? key2_q : key1_q;
	assign match      = rd_q.valid && (rd_q.key == cur_key);
	assign resolved   = !rd_q.valid || match;
	assign probe_last = probe_q == IDX_W'(TABLE_ENTRIES - 1);
	assign apply      = cmd.cmp && (resolved || probe_last);
	assign acc        = ACC_W'(run_q) + ACC_W'(rd_q.count);

	always_comb begin
		mem_we = 1'b0;
		mem_wd = '0;
		if (cmd.clr) begin
			mem_we = 1'b1;
		end else if (cmd.cmp && !query_q && resolved) begin
			mem_we       = 1'b1;
			mem_wd.valid = 1'b1;
			mem_wd.key   = cur_key;
			if (match)
				mem_wd.count = (rd_q.count == COUNT_MAX) ? COUNT_MAX : rd_q.count + 1'b1;
			else
				mem_wd.count = COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[idx_q] <= mem_wd;
		if (cmd.rd)
			rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.hash)
			prod_s1 <= 32'(32'(cur_key) * HASH_MULT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= 1'b0;
			last_q  <= 1'b0;
			need1_q <= 1'b0;
			need2_q <= 1'b0;
			phase_q <= 1'b0;
			full_q  <= 1'b0;
			prev_q  <= '0;
			pos_q   <= '0;
			key1_q  <= '0;
			key2_q  <= '0;
			idx_q   <= '0;
			probe_q <= '0;
			run_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.clr)
				idx_q <= idx_q + 1'b1;
			if (cmd.accept) begin
				query_q <= mode;
				last_q  <= last_byte;
				key1_q  <= (pos_q == 2'd1) ? {char_byte, prev_q[7:0], SPACE_BYTE}
				                           : {char_byte, prev_q[7:0], prev_q[15:8]};
				key2_q  <= {SPACE_BYTE, char_byte, prev_q[7:0]};
				need1_q <= pos_q != 2'd0;
				need2_q <= last_byte && (pos_q != 2'd0);
				phase_q <= 1'b0;
				prev_q  <= {prev_q[7:0], char_byte};
				pos_q   <= (pos_q == 2'd2) ? 2'd2 : pos_q + 2'd1;
			end
			if (cmd.probe_init) begin
				idx_q   <= prod_s1[8 +: IDX_W];
				probe_q <= '0;
			end
			if (cmd.cmp && !apply) begin
				idx_q   <= idx_q + 1'b1;
				probe_q <= probe_q + 1'b1;
			end
			if (apply) begin
				if (query_q) begin
					if (match)
						run_q <= (acc >= ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
				end else begin
					if (!resolved)
						full_q <= 1'b1;
					if (total_q != SUM_MAX)
						total_q <= total_q + 1'b1;
				end
			end
			if (cmd.next_key)
				phase_q <= 1'b1;
			if (cmd.finish) begin
				run_q  <= '0;
				pos_q  <= '0;
				prev_q <= '0;
			end
		end
	end

	assign sts.clr_last   = idx_q == IDX_W'(TABLE_ENTRIES - 1);
	assign sts.need1      = need1_q;
	assign sts.need2      = need2_q;
	assign sts.last       = last_q;
	assign sts.phase      = phase_q;
	assign sts.resolved   = resolved;
	assign sts.probe_last = probe_last;

	assign weight_sum     = query_q ? run_q : '0;
	assign total_trigrams = total_q;
	assign table_full     = full_q;

endmodule

`default_nettype wire

>>> rtl/atc_ctrl.sv
// atc_ctrl: sequencer for clearing, hashing, probing and result transfer
// depends on atc_pkg; commands atc_dp
`default_nettype none

module atc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire atc_pkg::sts_t sts,
	output atc_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import atc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_HASH;
			ST_HASH: begin
				if (sts.need1)
					state_d = ST_INDEX;
				else
					state_d = sts.last ? ST_DONE : ST_IDLE;
			end
			ST_INDEX: state_d = ST_READ;
			ST_READ:  state_d = ST_CMP;
			ST_CMP: begin
				if (sts.resolved || sts.probe_last) begin
					if (!sts.phase && sts.need2)
						state_d = ST_HASH;
					else
						state_d = sts.last ? ST_DONE : ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_HASH:  cmd.hash = 1'b1;
			ST_INDEX: cmd.probe_init = 1'b1;
			ST_READ:  cmd.rd = 1'b1;
			ST_CMP: begin
				cmd.cmp      = 1'b1;
				// second trigram closes the word with a trailing space
				cmd.next_key = (sts.resolved || sts.probe_last) && !sts.phase && sts.need2;
			end
			ST_DONE: begin
				done       = 1'b1;
				cmd.finish = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/ascii_trigram_count_table.sv
// ascii_trigram_count_table: top level joining atc_ctrl and atc_dp
// depends on atc_pkg, atc_ctrl, atc_dp
//
// Bytes of a word are taken one per transfer (start high while busy low). After
// reset the block clears its 4096-entry table, one entry per cycle, with busy high.
// A byte closing no trigram passes through the hash state only. The first trigram of
// a byte adds the index state and a read and compare per probe of the open-addressed
// table, since every probe is a read then compare on the single memory port; the
// trailing-space trigram of a last byte adds the hash and index states again and a
// read and compare per probe, and the result adds the done state. With a full table
// a trigram can probe all 4096 entries. On the last byte done pulses for one cycle
// with the results; the receiver cannot stall and must take them then.
`default_nettype none

module ascii_trigram_count_table (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     mode,
	input  wire logic [7:0]               char_byte,
	input  wire logic                     last_byte,
	output logic                          done,
	output logic [atc_pkg::SUM_W-1:0]     weight_sum,
	output logic [atc_pkg::SUM_W-1:0]     total_trigrams,
	output logic                          table_full
);
	import atc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	atc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	atc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.char_byte      (char_byte),
		.last_byte      (last_byte),
		.weight_sum     (weight_sum),
		.total_trigrams (total_trigrams),
		.table_full     (table_full)
	);

endmodule

`default_nettype wire

>>> rtl/atc_checker.sv
// atc_checker: port-level checks for ascii_trigram_count_table
// depends on atc_pkg; attached to the top level by bind
`default_nettype none

module atc_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic                     table_full
);
	import atc_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result not a single-cycle pulse");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(table_full) && $past(arst_n) |-> table_full)
		else $error("table full flag dropped");

endmodule

bind ascii_trigram_count_table atc_checker u_atc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.table_full (table_full)
);

`default_nettype wire
